FILE: sv/ferp_pkg.sv
// Shared types, sizes and codes for the flash erase region planner.
package ferp_pkg;

    localparam int SECTOR_BYTES     = 4096;
    localparam int HALF_BLOCK_BYTES = 32768;
    localparam int BLOCK_BYTES      = 65536;
    localparam longint FLASH_BYTES  = 64'd33554432;

    localparam int ADDR_W  = 25;
    localparam int COUNT_W = 26;
    localparam int SUM_W   = COUNT_W + 1;

    localparam int SECTOR_LG = $clog2(SECTOR_BYTES);
    localparam int HALF_LG   = $clog2(HALF_BLOCK_BYTES);
    localparam int BLOCK_LG  = $clog2(BLOCK_BYTES);

    localparam int IN_DATA_W  = ((ADDR_W + COUNT_W + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + ADDR_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SECTOR = 2'd1,
        KIND_HALF   = 2'd2,
        KIND_BLOCK  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_ISSUED     = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_INVALID    = 3'd2,
        ST_FAILED     = 3'd3,
        ST_BUSY       = 3'd4,
        ST_UNEXPECTED = 3'd5
    } t_status;

    typedef struct packed {
        logic               busy;
        logic [ADDR_W-1:0]  next_addr;
        logic [COUNT_W-1:0] bytes_left;
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [ADDR_W-1:0]  start_addr;
        logic [COUNT_W-1:0] byte_count;
        logic               erase_ok;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_result;

endpackage

FILE: sv/ferp_step.sv
// Combinational planner step: one item plus current state gives result and next state.
module ferp_step (
    input  ferp_pkg::t_state  i_state,
    input  ferp_pkg::t_item   i_item,
    output ferp_pkg::t_state  o_state,
    output ferp_pkg::t_result o_result
);

    logic                           req_bad;
    logic [ferp_pkg::SUM_W-1:0]     req_end;
    logic [ferp_pkg::ADDR_W-1:0]    pos;
    logic [ferp_pkg::COUNT_W-1:0]   left;
    logic [ferp_pkg::COUNT_W-1:0]   size;
    logic [ferp_pkg::COUNT_W-1:0]   step;
    ferp_pkg::t_kind                kind;
    logic                           do_issue;

    assign req_end = ferp_pkg::SUM_W'(i_item.start_addr) + ferp_pkg::SUM_W'(i_item.byte_count);
    assign req_bad = (i_item.start_addr[ferp_pkg::SECTOR_LG-1:0] != '0)
                  || (i_item.byte_count[ferp_pkg::SECTOR_LG-1:0] != '0)
                  || (64'(req_end) > ferp_pkg::FLASH_BYTES);

    // A fresh request plans from its own start; a completion continues the run.
    assign pos  = (i_item.cmd == ferp_pkg::CMD_START) ? i_item.start_addr : i_state.next_addr;
    assign left = (i_item.cmd == ferp_pkg::CMD_START) ? i_item.byte_count : i_state.bytes_left;

    always_comb begin
        if (pos[ferp_pkg::HALF_LG-1:0] != '0) begin
            kind = ferp_pkg::KIND_SECTOR;
            size = ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES);
        end else if (pos[ferp_pkg::BLOCK_LG-1:0] != '0
                     && left >= ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES)) begin
            kind = ferp_pkg::KIND_HALF;
            size = ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES);
        end else if (left >= ferp_pkg::COUNT_W'(ferp_pkg::BLOCK_BYTES)) begin
            kind = ferp_pkg::KIND_BLOCK;
            size = ferp_pkg::COUNT_W'(ferp_pkg::BLOCK_BYTES);
        end else if (left >= ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES)) begin
            kind = ferp_pkg::KIND_HALF;
            size = ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES);
        end else begin
            kind = ferp_pkg::KIND_SECTOR;
            size = ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES);
        end
    end

    assign step = (size > left) ? left : size;

    always_comb begin
        o_state         = i_state;
        o_result.kind   = ferp_pkg::KIND_NONE;
        o_result.addr   = '0;
        o_result.status = ferp_pkg::ST_ISSUED;
        do_issue        = 1'b0;

        if (i_item.cmd == ferp_pkg::CMD_START) begin
            if (i_state.busy) begin
                o_result.status = ferp_pkg::ST_BUSY;
            end else if (req_bad) begin
                o_result.status = ferp_pkg::ST_INVALID;
            end else if (i_item.byte_count == '0) begin
                o_result.status = ferp_pkg::ST_COMPLETE;
            end else begin
                do_issue = 1'b1;
            end
        end else begin
            if (!i_state.busy) begin
                o_result.status = ferp_pkg::ST_UNEXPECTED;
            end else if (!i_item.erase_ok) begin
                o_state.busy       = 1'b0;
                o_state.bytes_left = '0;
                o_result.status    = ferp_pkg::ST_FAILED;
            end else if (i_state.bytes_left == '0) begin
                o_state.busy    = 1'b0;
                o_result.status = ferp_pkg::ST_COMPLETE;
            end else begin
                do_issue = 1'b1;
            end
        end

        if (do_issue) begin
            o_state.busy       = 1'b1;
            o_state.next_addr  = pos + step[ferp_pkg::ADDR_W-1:0];
            o_state.bytes_left = left - step;
            o_result.kind      = kind;
            o_result.addr      = pos;
            o_result.status    = ferp_pkg::ST_ISSUED;
        end
    end

endmodule

FILE: sv/flash_erase_region_planner.sv
// Flash erase region planner: takes an erase request and then one completion per issued
// erase, and answers each transfer with one result: the next sector, half-block or block
// erase to issue, or a status (complete, invalid request, erase failed, busy, unexpected
// completion). One item is taken per clock while the output is not stalled; each item is
// held in the input register, passes the single planning step and is captured in the result
// register. s_axis_tready follows m_axis_tready combinationally when both registers are full.
module flash_erase_region_planner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_addr[24:0], byte_count[50:25], erase_ok[51], zeros above
    input  logic [ferp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // erase_kind[1:0], erase_addr[26:2], zeros above
    output logic [ferp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]                      m_axis_tuser
);

    localparam int CNT_LO = ferp_pkg::ADDR_W;
    localparam int OK_BIT = ferp_pkg::ADDR_W + ferp_pkg::COUNT_W;

    logic              r_in_valid;
    ferp_pkg::t_item   r_in_item;
    ferp_pkg::t_state  r_state;
    logic              r_out_valid;
    ferp_pkg::t_result r_out;

    ferp_pkg::t_state  n_state;
    ferp_pkg::t_result n_out;
    ferp_pkg::t_item   in_item;
    logic              advance;
    logic              in_xfer;

    assign in_item.cmd        = ferp_pkg::t_cmd'(s_axis_tuser);
    assign in_item.start_addr = s_axis_tdata[ferp_pkg::ADDR_W-1:0];
    assign in_item.byte_count = s_axis_tdata[CNT_LO +: ferp_pkg::COUNT_W];
    assign in_item.erase_ok   = s_axis_tdata[OK_BIT];

    // Held item moves on when the result register is free or draining.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ferp_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ferp_pkg::OUT_DATA_W'({r_out.addr, r_out.kind});
    assign m_axis_tuser  = r_out.status;

endmodule

FILE: dv/flash_erase_region_planner_chk.sv
// Checker for the flash erase region planner: predicts each result and compares the outputs.
`timescale 1ns / 1ps

module flash_erase_region_planner_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // start_addr[24:0], byte_count[50:25], erase_ok[51], zeros above
    input  logic [ferp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // erase_kind[1:0], erase_addr[26:2], zeros above
    input  logic [ferp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    input  logic [2:0]                      m_axis_tuser,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic                            o_plan_busy
);

    // planner state as predicted from the accepted transfers
    logic [ferp_pkg::ADDR_W-1:0]  cur_addr;
    logic [ferp_pkg::COUNT_W-1:0] remaining;
    logic                         running;

    ferp_pkg::t_result planned_results[$];

    initial begin
        cur_addr     = '0;
        remaining    = '0;
        running      = 1'b0;
        o_fail_count = 0;
        o_pending    = 0;
        o_plan_busy  = 1'b0;
    end

    // Pick the largest erase allowed by the current alignment and remaining size.
    function automatic ferp_pkg::t_result issue_next_erase();
        ferp_pkg::t_result            res;
        logic [ferp_pkg::COUNT_W-1:0] span;
        if (cur_addr[ferp_pkg::HALF_LG-1:0] != '0) begin
            res.kind = ferp_pkg::KIND_SECTOR;
        end else if (cur_addr[ferp_pkg::BLOCK_LG-1:0] != '0
                     && remaining >= ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES)) begin
            res.kind = ferp_pkg::KIND_HALF;
        end else if (remaining >= ferp_pkg::COUNT_W'(ferp_pkg::BLOCK_BYTES)) begin
            res.kind = ferp_pkg::KIND_BLOCK;
        end else if (remaining >= ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES)) begin
            res.kind = ferp_pkg::KIND_HALF;
        end else begin
            res.kind = ferp_pkg::KIND_SECTOR;
        end
        case (res.kind)
            ferp_pkg::KIND_BLOCK: span = ferp_pkg::COUNT_W'(ferp_pkg::BLOCK_BYTES);
            ferp_pkg::KIND_HALF:  span = ferp_pkg::COUNT_W'(ferp_pkg::HALF_BLOCK_BYTES);
            default:              span = ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES);
        endcase
        if (span > remaining) span = remaining;
        res.addr   = cur_addr;
        res.status = ferp_pkg::ST_ISSUED;
        cur_addr   = cur_addr + span[ferp_pkg::ADDR_W-1:0];
        remaining  = remaining - span;
        running    = 1'b1;
        return res;
    endfunction

    function automatic ferp_pkg::t_result plan_erase_step(input ferp_pkg::t_item it);
        ferp_pkg::t_result          res;
        logic [ferp_pkg::SUM_W-1:0] region_end;
        res.kind   = ferp_pkg::KIND_NONE;
        res.addr   = '0;
        res.status = ferp_pkg::ST_ISSUED;
        region_end = ferp_pkg::SUM_W'(it.start_addr) + ferp_pkg::SUM_W'(it.byte_count);
        if (it.cmd == ferp_pkg::CMD_START) begin
            if (running) begin
                res.status = ferp_pkg::ST_BUSY;
            end else if (it.start_addr[ferp_pkg::SECTOR_LG-1:0] != '0 ||
                         it.byte_count[ferp_pkg::SECTOR_LG-1:0] != '0 ||
                         64'(region_end) > ferp_pkg::FLASH_BYTES) begin
                res.status = ferp_pkg::ST_INVALID;
            end else if (it.byte_count == '0) begin
                res.status = ferp_pkg::ST_COMPLETE;
            end else begin
                cur_addr  = it.start_addr;
                remaining = it.byte_count;
                res       = issue_next_erase();
            end
        end else if (!running) begin
            res.status = ferp_pkg::ST_UNEXPECTED;
        end else if (!it.erase_ok) begin
            running    = 1'b0;
            remaining  = '0;
            res.status = ferp_pkg::ST_FAILED;
        end else if (remaining == '0) begin
            running    = 1'b0;
            res.status = ferp_pkg::ST_COMPLETE;
        end else begin
            res = issue_next_erase();
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        ferp_pkg::t_item   it;
        ferp_pkg::t_result got;
        ferp_pkg::t_result want;
        if (!i_rst_n) begin
            cur_addr  = '0;
            remaining = '0;
            running   = 1'b0;
            planned_results.delete();
        end else begin
            // compare first: a result leaving now belongs to an earlier transfer
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = ferp_pkg::t_kind'(m_axis_tdata[1:0]);
                got.addr   = m_axis_tdata[2 +: ferp_pkg::ADDR_W];
                got.status = ferp_pkg::t_status'(m_axis_tuser);
                if (planned_results.size() == 0) begin
                    $error("unexpected result transfer: erase_kind %0d erase_addr 'h%0h status %0d",
                           got.kind, got.addr, got.status);
                    o_fail_count++;
                end else begin
                    want = planned_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("erase_kind: expected %0d, got %0d", want.kind, got.kind);
                        o_fail_count++;
                    end
                    if (got.addr !== want.addr) begin
                        $error("erase_addr: expected 'h%0h, got 'h%0h", want.addr, got.addr);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.cmd        = ferp_pkg::t_cmd'(s_axis_tuser);
                it.start_addr = s_axis_tdata[ferp_pkg::ADDR_W-1:0];
                it.byte_count = s_axis_tdata[ferp_pkg::ADDR_W +: ferp_pkg::COUNT_W];
                it.erase_ok   = s_axis_tdata[ferp_pkg::ADDR_W+ferp_pkg::COUNT_W];
                planned_results.push_back(plan_erase_step(it));
            end
        end
        o_pending   = planned_results.size();
        o_plan_busy = running;
    end

endmodule

FILE: dv/flash_erase_region_planner_tb.sv
// Testbench top for the flash erase region planner: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module flash_erase_region_planner_tb;

    localparam int RANDOM_ITEMS = 1100;
    localparam int PAUSE_EVERY  = 250;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ferp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ferp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]                      m_axis_tuser;

    int   fail_count;
    int   pending;
    logic plan_busy;

    int   n_sent      = 0;
    int   burst_left  = 0;
    int   rdy_mode    = 0;
    int   rdy_left    = 0;
    logic force_ready = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    flash_erase_region_planner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    flash_erase_region_planner_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_plan_busy   (plan_busy)
    );

    // Receiver: segments of always-ready, light stalls, heavy stalls and a periodic stall.
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(8, 64);
        end
        rdy_left--;
        if (force_ready) begin
            m_axis_tready <= 1'b1;
        end else begin
            case (rdy_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rdy_left % 16) < 4);
            endcase
        end
    end

    function automatic ferp_pkg::t_item mk_item(input ferp_pkg::t_cmd cmd,
                                                input logic [ferp_pkg::ADDR_W-1:0] start_addr,
                                                input logic [ferp_pkg::COUNT_W-1:0] byte_count,
                                                input logic erase_ok);
        ferp_pkg::t_item it;
        it.cmd        = cmd;
        it.start_addr = start_addr;
        it.byte_count = byte_count;
        it.erase_ok   = erase_ok;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input ferp_pkg::t_item it);
        logic [ferp_pkg::IN_DATA_W-1:0] word;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        word = ferp_pkg::IN_DATA_W'({it.erase_ok, it.byte_count, it.start_addr});
        s_axis_tdata  <= word;
        s_axis_tuser  <= it.cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_finish(input logic ok);
        send_item(mk_item(ferp_pkg::CMD_FINISH,
                          ferp_pkg::ADDR_W'($urandom_range(0, 2**ferp_pkg::ADDR_W - 1)),
                          ferp_pkg::COUNT_W'($urandom_range(0, 2**ferp_pkg::ADDR_W)), ok));
    endtask

    // A valid request, then completions and stray requests until the planner goes idle.
    task automatic run_erase_region();
        int nsec;
        int base;
        int len;
        while (plan_busy) send_finish(1'($urandom_range(0, 1)));
        nsec = ($urandom_range(0, 99) < 6) ? $urandom_range(64, 1024) : $urandom_range(0, 40);
        len  = nsec * ferp_pkg::SECTOR_BYTES;
        base = $urandom_range(0, 8191) * ferp_pkg::SECTOR_BYTES;
        if ($urandom_range(0, 4) == 0 || base + len > ferp_pkg::FLASH_BYTES) begin
            base = int'(ferp_pkg::FLASH_BYTES) - len;
        end
        send_item(mk_item(ferp_pkg::CMD_START, ferp_pkg::ADDR_W'(base),
                          ferp_pkg::COUNT_W'(len), 1'($urandom_range(0, 1))));
        while (plan_busy) begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(mk_item(ferp_pkg::CMD_START,
                    ferp_pkg::ADDR_W'($urandom_range(0, 8191) * ferp_pkg::SECTOR_BYTES),
                    ferp_pkg::COUNT_W'($urandom_range(0, 64) * ferp_pkg::SECTOR_BYTES),
                    1'($urandom_range(0, 1))));
            end else begin
                send_finish($urandom_range(0, 39) != 0);
            end
        end
        if ($urandom_range(0, 11) == 0) send_finish(1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(mk_item(ferp_pkg::t_cmd'($urandom_range(0, 1)),
                                 ferp_pkg::ADDR_W'($urandom_range(0, 2**ferp_pkg::ADDR_W - 1)),
                                 ferp_pkg::COUNT_W'($urandom_range(0, 2**ferp_pkg::ADDR_W)),
                                 1'($urandom_range(0, 1))));
            // aligned request, about half the time running past the end of the flash
            1: send_item(mk_item(ferp_pkg::CMD_START,
                    ferp_pkg::ADDR_W'($urandom_range(0, 8191) * ferp_pkg::SECTOR_BYTES),
                    ferp_pkg::COUNT_W'($urandom_range(0, 8192) * ferp_pkg::SECTOR_BYTES),
                    1'($urandom_range(0, 1))));
            default: send_finish(1'($urandom_range(0, 1)));
        endcase
    endtask

    initial begin
        int next_pause;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // completion while idle, both outcomes
        send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b1));
        send_item(mk_item(ferp_pkg::CMD_FINISH, '1, '1, 1'b0));
        // empty request
        send_item(mk_item(ferp_pkg::CMD_START, '0, '0, 1'b0));
        // misaligned start, misaligned count, region past the end
        send_item(mk_item(ferp_pkg::CMD_START, '1,
                          ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES), 1'b1));
        send_item(mk_item(ferp_pkg::CMD_START, '0, '1, 1'b0));
        send_item(mk_item(ferp_pkg::CMD_START,
                          ferp_pkg::ADDR_W'(ferp_pkg::FLASH_BYTES - ferp_pkg::SECTOR_BYTES),
                          ferp_pkg::COUNT_W'(2 * ferp_pkg::SECTOR_BYTES), 1'b0));
        // last sector of the flash, a request while busy, then the last completion
        send_item(mk_item(ferp_pkg::CMD_START,
                          ferp_pkg::ADDR_W'(ferp_pkg::FLASH_BYTES - ferp_pkg::SECTOR_BYTES),
                          ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES), 1'b1));
        send_item(mk_item(ferp_pkg::CMD_START, '0,
                          ferp_pkg::COUNT_W'(ferp_pkg::SECTOR_BYTES), 1'b0));
        send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b1));
        // whole flash, stopped by a failed erase, then a stray completion
        send_item(mk_item(ferp_pkg::CMD_START, '0,
                          ferp_pkg::COUNT_W'(ferp_pkg::FLASH_BYTES), 1'b0));
        send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b1));
        send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b0));
        send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b1));
        // sector, half, block, half, two sectors
        send_item(mk_item(ferp_pkg::CMD_START, 25'h7000, 26'h23000, 1'b0));
        repeat (7) send_item(mk_item(ferp_pkg::CMD_FINISH, '0, '0, 1'b1));
        hold_until_drained();

        next_pause = n_sent + PAUSE_EVERY;
        while (n_sent < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 99) < 75) run_erase_region();
            else send_noise();
            if (n_sent >= next_pause) begin
                hold_until_drained();
                next_pause = n_sent + PAUSE_EVERY;
            end
        end
        s_axis_tvalid <= 1'b0;
        force_ready = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
